/* design/ilist_pkg.sv */
// ---------------------------------------------------------------------------
// ilist_pkg
// Shared widths, operation codes and status codes for the indexed list engine.
// ---------------------------------------------------------------------------
package ilist_pkg;

    localparam int VALUE_W          = 32;
    localparam int POS_W            = 11;
    localparam int MODE_W           = 3;
    localparam int STATUS_W         = 2;
    localparam int CAPACITY_DEFAULT = 64;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_READ       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INS_HEAD   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_APPEND     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INS_AT     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DELETE     = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // Value returned by a read at an invalid position
    localparam logic [VALUE_W-1:0] READ_MISS = {VALUE_W{1'b1}};

    typedef logic [VALUE_W-1:0] value_t;

endpackage

/* design/ilist_ram.sv */
// ---------------------------------------------------------------------------
// ilist_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ---------------------------------------------------------------------------
module ilist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/indexed_list_engine.sv */
// From acceptance to the result register: a rejected item goes straight to S_FIN,
// a read passes S_RDWAIT, an insert shifts in S_INS if anything is to shift and
// then writes its value in S_WRVAL, a delete shifts in S_DEL if anything is to
// shift; entries move one place each, one per cycle. A result still waiting at
// the output holds the new one back for as long. One item at a time; the next is
// taken the cycle after the result is registered, even while that result waits.
// ---------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of signed 32-bit values kept in a RAM plus an entry count.
// Inserts and deletes shift the tail of the list one entry per cycle.
// Reset: rst_n clears the list to empty; RAM contents are not cleared.
// ---------------------------------------------------------------------------
module indexed_list_engine
    import ilist_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [MODE_W-1:0]          mode,
    input  logic [POS_W-1:0]           position,
    input  logic signed [VALUE_W-1:0]  item_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [VALUE_W-1:0]  read_value,
    output logic [STATUS_W-1:0]        status,
    output logic [POS_W-1:0]           entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RDWAIT = 3'd1;
    localparam logic [2:0] S_INS    = 3'd2;
    localparam logic [2:0] S_WRVAL  = 3'd3;
    localparam logic [2:0] S_DEL    = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       new_count_reg, new_count_next;
    logic [AW-1:0]       src_reg, src_next;
    logic [AW-1:0]       ipos_reg, ipos_next;
    value_t              ival_reg, ival_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;
    value_t              res_value_reg, res_value_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    value_t              out_value_reg, out_value_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [CW-1:0]       out_count_reg, out_count_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    value_t              ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    value_t              ram_rdata;

    logic [POS_W-1:0]    count_ext;
    logic [POS_W-1:0]    ins_pos;
    logic [AW-1:0]       last_idx;
    logic                accept;
    logic                out_free;

    assign count_ext = POS_W'(count_reg);
    assign last_idx  = AW'(count_reg - CW'(1));
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    // Insert position per mode
    always_comb
    begin
        case (mode)
            MODE_INS_HEAD: ins_pos = '0;
            MODE_APPEND:   ins_pos = count_ext;
            default:       ins_pos = position;
        endcase
    end

    // List store
    ilist_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Write port: a pending shift write goes first, then the new value
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;
        if (pend_valid_reg)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_WRVAL)
        begin
            ram_we    = 1'b1;
            ram_waddr = ipos_reg;
            ram_wdata = ival_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        new_count_next  = new_count_reg;
        src_next        = src_reg;
        ipos_next       = ipos_reg;
        ival_next       = ival_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        ram_re          = 1'b0;
        ram_raddr       = src_reg;
        in_ready        = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    new_count_next  = count_reg;
                    res_value_next  = '0;
                    res_status_next = ST_INVALID;
                    ival_next       = value_t'(item_value);
                    ipos_next       = AW'(ins_pos);
                    state_next      = S_FIN;
                    case (mode)
                        MODE_READ:
                        begin
                            if (position < count_ext)
                            begin
                                ram_re          = 1'b1;
                                ram_raddr       = AW'(position);
                                res_status_next = ST_DONE;
                                state_next      = S_RDWAIT;
                            end
                            else
                            begin
                                res_value_next = READ_MISS;
                            end
                        end
                        MODE_INS_HEAD, MODE_APPEND, MODE_INS_AT:
                        begin
                            if (ins_pos > count_ext)
                            begin
                                res_status_next = ST_INVALID;
                            end
                            else if (count_reg == CAP_C)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                res_status_next = ST_DONE;
                                new_count_next  = count_reg + CW'(1);
                                src_next        = last_idx;
                                state_next      = (ins_pos < count_ext) ? S_INS : S_WRVAL;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (position < count_ext)
                            begin
                                res_status_next = ST_DONE;
                                new_count_next  = count_reg - CW'(1);
                                src_next        = AW'(position + POS_W'(1));
                                if ((position + POS_W'(1)) < count_ext)
                                begin
                                    state_next = S_DEL;
                                end
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_INVALID;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                res_value_next = ram_rdata;
                state_next     = S_FIN;
            end
            // Move entries up, from the tail down to the insert position
            S_INS:
            begin
                ram_re          = 1'b1;
                pend_valid_next = 1'b1;
                pend_addr_next  = src_reg + AW'(1);
                if (src_reg == ipos_reg)
                begin
                    state_next = S_WRVAL;
                end
                else
                begin
                    src_next = src_reg - AW'(1);
                end
            end
            S_WRVAL:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_FIN;
                end
            end
            // Move entries down, from just past the position to the tail
            S_DEL:
            begin
                ram_re          = 1'b1;
                pend_valid_next = 1'b1;
                pend_addr_next  = src_reg - AW'(1);
                if (src_reg == last_idx)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    src_next = src_reg + AW'(1);
                end
            end
            S_FIN:
            begin
                if (!pend_valid_reg && out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = new_count_reg;
                    count_next      = new_count_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        new_count_reg  <= new_count_next;
        src_reg        <= src_next;
        ipos_reg       <= ipos_next;
        ival_reg       <= ival_next;
        pend_addr_reg  <= pend_addr_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign read_value  = out_value_reg;
    assign status      = out_status_reg;
    assign entry_count = POS_W'(out_count_reg);

`ifndef NO_ASSERTIONS
    // Count never goes past the store size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count exceeds capacity");

    // No shift write may be left over once the sequencer is idle
    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("pending shift write while idle");

    // An accepted item always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("item accepted but sequencer stayed idle");

    // Count only moves when a result is registered
    a_count_update: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(state_reg) == S_FIN && out_valid_reg)
        else $error("count changed outside result load");
`endif

endmodule

/* tb/sv/list_result_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// list_result_checker
// Watches both channels of the indexed list engine, keeps its own copy of
// the list to predict each result, and compares every result field by field.
// ---------------------------------------------------------------------------
module list_result_checker
    import ilist_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic [MODE_W-1:0]         mode,
    input  logic [POS_W-1:0]          position,
    input  logic signed [VALUE_W-1:0] item_value,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [VALUE_W-1:0] read_value,
    input  logic [STATUS_W-1:0]       status,
    input  logic [POS_W-1:0]          entry_count,
    output int                        fail_count,
    output int                        pending,
    output int                        predicted_len
);

    typedef struct {
        value_t              read_value;
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    entry_count;
    } list_result_t;

    value_t       shadow_list [CAPACITY];
    int           shadow_len;
    list_result_t predicted_results [$];
    int           result_index;

    // Insert before pos; a position past the end is reported ahead of a full store
    function automatic logic [STATUS_W-1:0] insert_entry(input int pos, input value_t val);
        if (pos > shadow_len)
            return ST_INVALID;
        if (shadow_len >= CAPACITY)
            return ST_FULL;
        for (int i = shadow_len; i > pos; i--)
            shadow_list[i] = shadow_list[i-1];
        shadow_list[pos] = val;
        shadow_len++;
        return ST_DONE;
    endfunction

    // Apply one item to the shadow list and return the result it should give
    function automatic list_result_t apply_list_op(
        input logic [MODE_W-1:0] op,
        input logic [POS_W-1:0]  pos,
        input value_t            val
    );
        list_result_t r;
        r.read_value = '0;
        case (op)
            MODE_READ:
            begin
                if (int'(pos) < shadow_len)
                begin
                    r.read_value = shadow_list[pos];
                    r.status     = ST_DONE;
                end
                else
                begin
                    r.read_value = READ_MISS;
                    r.status     = ST_INVALID;
                end
            end
            MODE_INS_HEAD: r.status = insert_entry(0, val);
            MODE_APPEND:   r.status = insert_entry(shadow_len, val);
            MODE_INS_AT:   r.status = insert_entry(int'(pos), val);
            MODE_DELETE:
            begin
                if (int'(pos) >= shadow_len)
                    r.status = ST_INVALID;
                else
                begin
                    for (int i = int'(pos); i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                    r.status = ST_DONE;
                end
            end
            default: r.status = ST_INVALID;
        endcase
        r.entry_count = shadow_len[POS_W-1:0];
        return r;
    endfunction

    // Results are compared before new items are predicted in the same cycle
    always @(posedge clk or negedge rst_n)
    begin
        list_result_t exp_r;
        if (!rst_n)
        begin
            shadow_len = 0;
            predicted_results.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_index++;
                if (predicted_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result %0d arrived with nothing outstanding: value %h status %0d count %0d",
                                 result_index, read_value, status, entry_count);
                end
                else
                begin
                    exp_r = predicted_results.pop_front();
                    if (read_value !== exp_r.read_value || status !== exp_r.status ||
                        entry_count !== exp_r.entry_count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"result %0d mismatch: expected value %h status %0d count %0d,",
                                      " got value %h status %0d count %0d"},
                                     result_index, exp_r.read_value, exp_r.status,
                                     exp_r.entry_count, read_value, status, entry_count);
                    end
                end
            end
            if (in_valid && in_ready)
                predicted_results.push_back(apply_list_op(mode, position, item_value));
        end
        pending       = predicted_results.size();
        predicted_len = shadow_len;
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives the indexed list engine with a directed opening and then random
// phases that grow, drain, fill and scramble the list; a checker alongside
// predicts and compares every result.
// ---------------------------------------------------------------------------
module testbench;
    import ilist_pkg::*;

    localparam int    CAPACITY     = CAPACITY_DEFAULT;
    localparam int    TOTAL_ITEMS  = 1725;
    localparam int    QUIET_ITEMS  = 200;
    localparam int    SETTLE_CYCLES = CAPACITY + 20;
    localparam int    POS_MAX      = (1 << POS_W) - 1;
    localparam longint CYCLE_LIMIT = 1000000;

    typedef enum int {PH_MIXED, PH_GROW, PH_DRAIN, PH_NOISE} phase_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [MODE_W-1:0]         mode;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] item_value;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [VALUE_W-1:0] read_value;
    logic [STATUS_W-1:0]       status;
    logic [POS_W-1:0]          entry_count;

    int     fail_count;
    int     pending;
    int     list_len;
    bit     idle_on;
    int     items_sent;
    longint cycle_count;

    indexed_list_engine #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .position   (position),
        .item_value (item_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .status     (status),
        .entry_count(entry_count)
    );

    list_result_checker #(
        .CAPACITY(CAPACITY)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .position     (position),
        .item_value   (item_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_value   (read_value),
        .status       (status),
        .entry_count  (entry_count),
        .fail_count   (fail_count),
        .pending      (pending),
        .predicted_len(list_len)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** indexed_list_engine: FAILED **");
            $finish;
        end
    end

    // Result side: random stall bursts while idling is on
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge clk);
            end
            else
            begin
                out_ready = 1'b1;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input logic [MODE_W-1:0] op, input logic [POS_W-1:0] pos,
                             input value_t val);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid   = 1'b1;
        mode       = op;
        position   = pos;
        item_value = val;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        idle_on = (items_sent < TOTAL_ITEMS - QUIET_ITEMS);
        @(negedge clk);
    endtask

    // Hold the sender until every outstanding result is back
    task automatic drain_results();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Extremes come up often
    function automatic value_t random_value();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(VALUE_W-1){1'b0}}};
            1:       return {1'b0, {(VALUE_W-1){1'b1}}};
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Mostly in range, sometimes at or just past the end, now and then anywhere
    function automatic logic [POS_W-1:0] random_position(input int len, input bit for_insert);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return POS_W'($urandom_range(0, POS_MAX));
        if (r == 1)
            return POS_W'(len + 1);
        if (r == 2 || len == 0)
            return POS_W'(len);
        return POS_W'($urandom_range(0, for_insert ? len : len - 1));
    endfunction

    function automatic logic [MODE_W-1:0] random_mode(input phase_t ph);
        int r;
        r = $urandom_range(0, 9);
        case (ph)
            PH_GROW:
                if (r < 2)      return MODE_READ;
                else if (r < 4) return MODE_INS_HEAD;
                else if (r < 6) return MODE_APPEND;
                else if (r < 9) return MODE_INS_AT;
                else            return MODE_DELETE;
            PH_DRAIN:
                if (r < 2)      return MODE_READ;
                else if (r < 9) return MODE_DELETE;
                else            return MODE_INS_AT;
            PH_NOISE:
                return MODE_W'($urandom_range(0, (1 << MODE_W) - 1));
            default:
                return MODE_W'($urandom_range(MODE_READ, MODE_DELETE));
        endcase
    endfunction

    task automatic random_item(input phase_t ph);
        logic [MODE_W-1:0] op;
        logic [POS_W-1:0]  pos;
        op = random_mode(ph);
        if (ph == PH_NOISE || op == MODE_INS_HEAD || op == MODE_APPEND)
            pos = POS_W'($urandom_range(0, POS_MAX));
        else
            pos = random_position(list_len, op == MODE_INS_AT);
        send_item(op, pos, random_value());
    endtask

    // Fill the store, then try every kind of insert against it
    task automatic fill_and_probe();
        while (list_len < CAPACITY)
            send_item(MODE_APPEND, POS_W'($urandom_range(0, POS_MAX)), random_value());
        send_item(MODE_INS_HEAD, '0, random_value());
        send_item(MODE_APPEND, '0, random_value());
        send_item(MODE_INS_AT, POS_W'($urandom_range(0, CAPACITY - 1)), random_value());
        send_item(MODE_INS_AT, POS_W'(CAPACITY), random_value());
        send_item(MODE_INS_AT, POS_W'(CAPACITY + 1), random_value());
        send_item(MODE_READ, POS_W'(CAPACITY - 1), '0);
        send_item(MODE_DELETE, POS_W'(CAPACITY), '0);
    endtask

    initial
    begin
        phase_t ph;
        int     run_len;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_READ;
        position   = '0;
        item_value = '0;
        idle_on    = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed opening: empty list, edges of position, unused modes
        send_item(MODE_READ, '0, '0);
        send_item(MODE_DELETE, '0, '0);
        send_item(MODE_INS_AT, POS_W'(1), 32'h1234_5678);
        send_item(MODE_INS_AT, '0, 32'h7FFF_FFFF);
        send_item(MODE_INS_HEAD, POS_W'(POS_MAX), 32'h8000_0000);
        send_item(MODE_APPEND, '0, '1);
        send_item(MODE_APPEND, POS_W'(POS_MAX), '0);
        send_item(MODE_INS_AT, POS_W'(2), 32'h5555_5555);
        send_item(MODE_INS_AT, POS_W'(5), 32'hAAAA_AAAA);
        send_item(MODE_INS_AT, POS_W'(7), 32'h0F0F_0F0F);
        for (int p = 0; p <= 6; p++)
            send_item(MODE_READ, POS_W'(p), '0);
        send_item(MODE_READ, POS_W'(POS_MAX), '0);
        send_item(MODE_DELETE, POS_W'(POS_MAX), '0);
        send_item(MODE_DELETE, POS_W'(5), '0);
        send_item(MODE_DELETE, '0, '0);
        for (int m = MODE_DELETE + 1; m < (1 << MODE_W); m++)
            send_item(MODE_W'(m), POS_W'(POS_MAX), '1);
        drain_results();

        // Random phases
        while (items_sent < TOTAL_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: ph = PH_MIXED;
                3, 4:    ph = PH_GROW;
                5, 6:    ph = PH_DRAIN;
                7:       ph = PH_NOISE;
                8:
                begin
                    fill_and_probe();
                    continue;
                end
                default:
                begin
                    drain_results();
                    continue;
                end
            endcase
            run_len = $urandom_range(30, 120);
            repeat (run_len)
            begin
                if (items_sent < TOTAL_ITEMS)
                    random_item(ph);
            end
        end

        // Wind down
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("** indexed_list_engine: PASSED **");
        else
            $display("** indexed_list_engine: FAILED **");
        $finish;
    end

endmodule
